// ===== rtl/core/srs_pkg.sv =====
// Shared widths and types for the systematic resampler.
package srs_pkg;

  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int SUM_W    = 22;
  localparam int PROD_W   = SUM_W + CNT_W;
  localparam int LHS_W    = 45;
  localparam int STEP_W   = SUM_W + FRAC_W;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  total;
    logic [FRAC_W-1:0] frac;
  } walk_cmd_t;

  typedef enum logic [5:0] {
    W_IDLE = 6'b000001,
    W_INIT = 6'b000010,
    W_READ = 6'b000100,
    W_MUL  = 6'b001000,
    W_CMP  = 6'b010000,
    W_EMIT = 6'b100000
  } walk_state_t;

endpackage

// ===== rtl/core/systematic_resampler.sv =====
// Systematic resampler top level: weight loader, cumulative memory and walk.
//
// Input channel (in_valid/in_ready): one particle weight per item. Each weight
// is added to a running sum and the sum is stored at the next memory entry;
// weights beyond MAX_PARTICLES are dropped. An item with is_last high closes
// the set and supplies random_fraction as the start offset.
// Loading takes one item per cycle while the walk is idle. After the last
// item the block stops taking input and emits N items on the output channel
// (out_valid/out_ready), one particle index each, last_of_run high on the
// final one. The walk sets up (latch, first memory read, multiply by N), then
// each index step is a memory read, a multiply by N and a compare, and each
// emitted index a compare, then the output register until its handshake; the
// read, multiply and compare of each step run serially.
// A zero total emits indices 0..N-1 with zero_total set.
// A stalled receiver holds the walk on the registered output item.
// Reset clears the loaded count, running sum and walk state; the memory is
// not cleared, since only entries of the current set are ever read.
module systematic_resampler #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srs_pkg::WEIGHT_W-1:0] weight,
  input  logic [srs_pkg::FRAC_W-1:0]   random_fraction,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [srs_pkg::IDX_W-1:0]    particle_index,
  output logic                         zero_total,
  output logic                         last_of_run
);
  import srs_pkg::*;

  localparam int ADDR_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic              has_room;
  logic              accept;
  logic              busy;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_data;
  walk_cmd_t         cmd;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign has_room = (count < CNT_W'(MAX_PARTICLES));
  assign sum_next = has_room ? (sum + SUM_W'(weight)) : sum;

  assign cmd.count = has_room ? (count + CNT_W'(1)) : count;
  assign cmd.total = sum_next;
  assign cmd.frac  = random_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
    end else if (accept) begin
      if (is_last) begin
        count <= '0;
        sum   <= '0;
      end else begin
        count <= cmd.count;
        sum   <= sum_next;
      end
    end
  end

  srs_cum_ram #(
    .DEPTH  (MAX_PARTICLES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (sum_next),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srs_walk #(
    .ADDR_W (ADDR_W)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .start          (accept && is_last),
    .cmd            (cmd),
    .busy           (busy),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .particle_index (particle_index),
    .zero_total     (zero_total),
    .last_of_run    (last_of_run)
  );

endmodule

// ===== rtl/core/srs_cum_ram.sv =====
// Cumulative weight memory: one write port, one registered read port.
module srs_cum_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [srs_pkg::SUM_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [srs_pkg::SUM_W-1:0] rd_data
);
  import srs_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/srs_walk.sv =====
// Resampling walk: steps the threshold over the stored cumulative sums.
module srs_walk #(
  parameter int ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  srs_pkg::walk_cmd_t        cmd,
  output logic                      busy,
  output logic [ADDR_W-1:0]         rd_addr,
  input  logic [srs_pkg::SUM_W-1:0] rd_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [srs_pkg::IDX_W-1:0] particle_index,
  output logic                      zero_total,
  output logic                      last_of_run
);
  import srs_pkg::*;

  walk_state_t       state;
  walk_cmd_t         cmd_q;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  k;
  logic [LHS_W-1:0]  lhs;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] prod;
  logic              zero;
  logic [CNT_W-1:0]  i_plus;
  logic [CNT_W-1:0]  k_plus;
  logic [LHS_W-1:0]  rhs;
  logic              advance;

  assign busy    = (state != W_IDLE);
  assign rd_addr = i[ADDR_W-1:0];
  assign i_plus  = {1'b0, i} + CNT_W'(1);
  assign k_plus  = {1'b0, k} + CNT_W'(1);
  assign rhs     = {prod, {FRAC_W{1'b0}}};
  assign advance = (i_plus < cmd_q.count) && (lhs > rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        W_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= W_INIT;
          end
        end
        W_INIT: begin
          lhs   <= LHS_W'(cmd_q.frac) * LHS_W'(cmd_q.total);
          step  <= {cmd_q.total, {FRAC_W{1'b0}}};
          zero  <= (cmd_q.total == '0);
          i     <= '0;
          k     <= '0;
          state <= W_READ;
        end
        W_READ: begin
          state <= W_MUL;
        end
        W_MUL: begin
          prod  <= PROD_W'(rd_data) * PROD_W'(cmd_q.count);
          state <= W_CMP;
        end
        W_CMP: begin
          if (!zero && advance) begin
            i     <= i_plus[IDX_W-1:0];
            state <= W_READ;
          end else begin
            out_valid      <= 1'b1;
            particle_index <= zero ? k : i;
            zero_total     <= zero;
            last_of_run    <= (k_plus == cmd_q.count);
            state          <= W_EMIT;
          end
        end
        W_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_of_run) begin
              state <= W_IDLE;
            end else begin
              k     <= k_plus[IDX_W-1:0];
              lhs   <= lhs + LHS_W'(step);
              state <= W_CMP;
            end
          end
        end
        default: begin
          state     <= W_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
